@@ hw/rtl/rfd_pkg.sv @@
// Shared types and constants for the frame deframer.
package rfd_pkg;

	// Frame phase of the deframer state machine
	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_META   = 2'd1,
		PH_BODY   = 2'd2
	} phase_t;

	// Section code reported with every byte
	typedef enum logic [1:0] {
		SEC_HEADER = 2'd0,
		SEC_META   = 2'd1,
		SEC_BODY   = 2'd2,
		SEC_DROP   = 2'd3
	} section_t;

	// Header byte positions
	localparam logic [4:0] HDR_MAGIC_HI = 5'd0;
	localparam logic [4:0] HDR_MAGIC_LO = 5'd1;
	localparam logic [4:0] HDR_VERSION  = 5'd2;
	localparam logic [4:0] HDR_TYPE     = 5'd3;
	localparam logic [4:0] HDR_SEQ_END  = 5'd12;
	localparam logic [4:0] HDR_META_END = 5'd16;
	localparam logic [4:0] HDR_LAST     = 5'd19;

	// Configuration register index
	localparam logic REG_MAGIC = 1'b0;

endpackage

@@ hw/rtl/rpc_frame_deframer_core.sv @@
// Length-prefixed frame deframer: header decode, section tagging and magic check.
//
// Usage:
//   Feed one received byte per request on the rx channel (rx_valid, rx_stall,
//   rx_byte). Every accepted byte yields exactly one result request on the out
//   channel: the byte itself, its section (header, meta, body or dropped), a
//   last-of-frame mark, the latched bad_magic flag and, on the twentieth
//   header byte, the decoded header fields (zero on every other byte).
//   A byte accepted at one edge is presented on out_valid right after that
//   edge from the single result register that follows the decode logic;
//   the block takes one byte per cycle while the receiver does not stall.
//   The expected magic sits in an APB register at byte address 0; write it
//   only while no byte is in flight.
//   Reset clears the frame state, the error flag, the magic register and the
//   result valid bit; the block then expects the first byte of a header.
//   When the receiver stalls, the held result stays unchanged and rx_stall
//   rises, so no new byte is taken until the held result leaves; a result
//   taken in the same cycle frees the register for the next byte at once.
//   After a magic mismatch every byte is still passed through, tagged as
//   dropped with bad_magic set, until reset.
module rpc_frame_deframer_core (
	input  logic        clk,
	input  logic        arst_n,
	// APB configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// Byte input channel
	input  logic        rx_valid,
	output logic        rx_stall,
	input  logic [7:0]  rx_byte,
	// Result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  byte_out,
	output logic [1:0]  section,
	output logic        frame_last,
	output logic        header_valid,
	output logic [7:0]  version,
	output logic [7:0]  msg_type,
	output logic [63:0] sequence_id,
	output logic [31:0] meta_length,
	output logic [31:0] body_length,
	output logic        bad_magic
);
	import rfd_pkg::*;

	// Frame state
	phase_t      phase_q, phase_d;
	logic [4:0]  hdr_idx_q, hdr_idx_d;
	logic [7:0]  magic_hi_q, magic_hi_d;
	logic [7:0]  version_q, version_d;
	logic [7:0]  type_q, type_d;
	logic [63:0] seq_q, seq_d;
	logic [31:0] meta_len_q, meta_len_d;
	logic [31:0] body_len_q, body_len_d;
	logic [31:0] remain_q, remain_d;
	logic        err_q, err_d;
	logic [15:0] magic_value_q;

	// Result register
	logic        out_valid_q;
	logic [7:0]  byte_q;
	section_t    sec_q;
	logic        last_q, hv_q;
	logic [7:0]  ver_out_q, type_out_q;
	logic [63:0] seq_out_q;
	logic [31:0] meta_out_q, body_out_q;
	logic        bad_q;

	// Decode results for the byte at the input
	section_t    sec_d;
	logic        last_d, hv_d;
	logic [31:0] remain_dec;
	logic        rx_take;
	logic        cfg_wr;

	assign pready   = 1'b1;
	assign cfg_wr   = psel & penable & pwrite;
	assign prdata   = (paddr[2] == REG_MAGIC) ? {16'd0, magic_value_q} : 32'd0;
	// Hold off the sender only while a result waits and the receiver stalls
	assign rx_stall = out_valid_q & out_stall;
	assign rx_take  = rx_valid & ~rx_stall;
	assign remain_dec = remain_q - 32'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_value_q <= '0;
		end else if (cfg_wr && paddr[2] == REG_MAGIC) begin
			magic_value_q <= pwdata[15:0];
		end
	end

	// Next frame state and the result of one byte
	always_comb begin
		phase_d    = phase_q;
		hdr_idx_d  = hdr_idx_q;
		magic_hi_d = magic_hi_q;
		version_d  = version_q;
		type_d     = type_q;
		seq_d      = seq_q;
		meta_len_d = meta_len_q;
		body_len_d = body_len_q;
		remain_d   = remain_q;
		err_d      = err_q;
		sec_d      = SEC_HEADER;
		last_d     = 1'b0;
		hv_d       = 1'b0;
		if (err_q) begin
			// Drop everything until reset
			sec_d = SEC_DROP;
		end else begin
			unique case (phase_q)
				PH_META, PH_BODY: begin
					sec_d    = (phase_q == PH_META) ? SEC_META : SEC_BODY;
					remain_d = remain_dec;
					if (remain_dec == 32'd0) begin
						if (phase_q == PH_META && body_len_q != 32'd0) begin
							phase_d  = PH_BODY;
							remain_d = body_len_q;
						end else begin
							phase_d = PH_HEADER;
							last_d  = 1'b1;
						end
					end
				end
				default: begin
					sec_d = SEC_HEADER;
					if (hdr_idx_q == HDR_MAGIC_HI) begin
						magic_hi_d = rx_byte;
					end else if (hdr_idx_q == HDR_MAGIC_LO) begin
						if ({magic_hi_q, rx_byte} != magic_value_q) begin
							err_d = 1'b1;
							sec_d = SEC_DROP;
						end
					end else if (hdr_idx_q == HDR_VERSION) begin
						version_d = rx_byte;
					end else if (hdr_idx_q == HDR_TYPE) begin
						type_d = rx_byte;
					end else if (hdr_idx_q < HDR_SEQ_END) begin
						seq_d = {seq_q[55:0], rx_byte};
					end else if (hdr_idx_q < HDR_META_END) begin
						meta_len_d = {meta_len_q[23:0], rx_byte};
					end else begin
						body_len_d = {body_len_q[23:0], rx_byte};
					end
					if (!err_d) begin
						if (hdr_idx_q >= HDR_LAST) begin
							hv_d      = 1'b1;
							hdr_idx_d = '0;
							if (meta_len_d != 32'd0) begin
								phase_d  = PH_META;
								remain_d = meta_len_d;
							end else if (body_len_d != 32'd0) begin
								phase_d  = PH_BODY;
								remain_d = body_len_d;
							end else begin
								phase_d = PH_HEADER;
								last_d  = 1'b1;
							end
						end else begin
							hdr_idx_d = hdr_idx_q + 5'd1;
							phase_d   = PH_HEADER;
						end
					end
				end
			endcase
		end
	end

	// Advance frame state on each accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HEADER;
			hdr_idx_q  <= '0;
			magic_hi_q <= '0;
			version_q  <= '0;
			type_q     <= '0;
			seq_q      <= '0;
			meta_len_q <= '0;
			body_len_q <= '0;
			remain_q   <= '0;
			err_q      <= 1'b0;
		end else if (rx_take) begin
			phase_q    <= phase_d;
			hdr_idx_q  <= hdr_idx_d;
			magic_hi_q <= magic_hi_d;
			version_q  <= version_d;
			type_q     <= type_d;
			seq_q      <= seq_d;
			meta_len_q <= meta_len_d;
			body_len_q <= body_len_d;
			remain_q   <= remain_d;
			err_q      <= err_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rx_take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Capture the result payload; header fields read zero on every byte but the last header byte
	always_ff @(posedge clk) begin
		if (rx_take) begin
			byte_q     <= rx_byte;
			sec_q      <= sec_d;
			last_q     <= last_d;
			hv_q       <= hv_d;
			ver_out_q  <= hv_d ? version_d  : 8'd0;
			type_out_q <= hv_d ? type_d     : 8'd0;
			seq_out_q  <= hv_d ? seq_d      : 64'd0;
			meta_out_q <= hv_d ? meta_len_d : 32'd0;
			body_out_q <= hv_d ? body_len_d : 32'd0;
			bad_q      <= err_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign byte_out     = byte_q;
	assign section      = sec_q;
	assign frame_last   = last_q;
	assign header_valid = hv_q;
	assign version      = ver_out_q;
	assign msg_type     = type_out_q;
	assign sequence_id  = seq_out_q;
	assign meta_length  = meta_out_q;
	assign body_length  = body_out_q;
	assign bad_magic    = bad_q;

	// The error flag never clears outside reset
	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		err_q |=> err_q)
		else $error("error flag cleared without reset");

	// A result with bad_magic set is always tagged as dropped
	a_bad_dropped: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && bad_magic) |-> (section == SEC_DROP))
		else $error("bad_magic result not tagged as dropped");

	// A decoded header only comes with a header byte and no error
	a_hv_header: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && header_valid) |-> (section == SEC_HEADER && !bad_magic))
		else $error("header_valid outside a clean header byte");

	// End of frame never marks a dropped byte
	a_last_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && frame_last) |-> (section != SEC_DROP && !bad_magic))
		else $error("frame_last on a dropped byte");

	// Header index rests at zero while in the meta or body section
	a_idx_rest: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_HEADER) |-> (hdr_idx_q == 5'd0))
		else $error("header index not cleared outside header");

endmodule
